[src/assert_macros.svh]
// Assertion shorthands shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every rising clk edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[src/ate_pkg.sv]
// ----------------------------------------------------------------------------
// ate_pkg
// Shared widths, constants, controller states and control structs of the
// adaptive time extrapolator.
// ----------------------------------------------------------------------------
`default_nettype none

package ate_pkg;

  // Fixed point time: 64 bits, TIME_FRAC_BITS of them fraction.
  localparam int TIME_FRAC_BITS = 32;
  localparam int TIME_W         = 64;
  localparam int CNT_W          = 32;

  // Rate threshold: poll about 1024 times a second.
  localparam int POLL_SHIFT = 10;
  localparam logic [CNT_W-1:0] RATE_RESET = CNT_W'(100000);

  // Scaled quotient is capped at 2^41.
  localparam int QUOT_CAP_LOG2 = 41;
  localparam int QUOT_W        = QUOT_CAP_LOG2 + 1;
  localparam logic [QUOT_W-1:0] QUOT_CAP = QUOT_W'(1) << QUOT_CAP_LOG2;

  // One quotient bit per divider step.
  localparam int DIV_STEPS = CNT_W + TIME_FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic capture;     // latch the accepted transaction
    logic div_start;   // launch the divider
    logic div_use_dt;  // divisor is the time difference, else the rate
    logic commit;      // write the result and update state
  } ate_cmd_t;

  typedef struct packed {
    logic poll;           // count reached threshold or query changed
    logic query_changed;  // query count differs from last seen
    logic time_advanced;  // sample is past the last poll time
    logic div_done;       // divider result ready
    logic out_free;       // output register can take a result
  } ate_status_t;

endpackage

`default_nettype wire

[src/ate_div.sv]
// ----------------------------------------------------------------------------
// ate_div
// Restoring divider for floor(numer * 2^TIME_FRAC_BITS / denom), one quotient
// bit per cycle, with the quotient capped at QUOT_CAP.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ate_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [ate_pkg::CNT_W-1:0]  numer,
  input  wire logic [ate_pkg::TIME_W-1:0] denom,
  output logic                            done,
  output logic [ate_pkg::QUOT_W-1:0]      quot
);
  import ate_pkg::*;

  logic                 running;
  logic [DIV_CNT_W-1:0] count;
  logic [TIME_W-1:0]    rem;
  logic [TIME_W-1:0]    dvsr;
  logic [CNT_W-1:0]     nsh;
  logic [QUOT_W-1:0]    q;
  logic                 sticky;

  logic [TIME_W-1:0] rem_sh;
  logic [TIME_W-1:0] rem_next;
  logic              take;
  logic [QUOT_W:0]   q_wide;
  logic              sticky_next;

  always_comb begin
    // Shift in the next numerator bit; zeros follow for the fraction.
    rem_sh      = {rem[TIME_W-2:0], nsh[CNT_W-1]};
    take        = rem[TIME_W-1] || (rem_sh >= dvsr);
    rem_next    = take ? (rem_sh - dvsr) : rem_sh;
    q_wide      = {q, take};
    sticky_next = sticky || (q_wide > {1'b0, QUOT_CAP});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        count   <= DIV_CNT_W'(DIV_STEPS);
      end else if (running) begin
        count <= count - DIV_CNT_W'(1);
        if (count == DIV_CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem    <= '0;
      dvsr   <= denom;
      nsh    <= numer;
      q      <= '0;
      sticky <= 1'b0;
    end else if (running) begin
      rem    <= rem_next;
      nsh    <= {nsh[CNT_W-2:0], 1'b0};
      q      <= q_wide[QUOT_W-1:0];
      sticky <= sticky_next;
    end
  end

  assign quot = sticky ? QUOT_CAP : q;

  `ASSERT_CLK(a_no_restart, start |-> !running, "divider restarted while busy")
  `ASSERT_CLK(a_done_idle, done |-> !running, "divider done while still running")
  `ASSERT_CLK(a_idle_count, !running |-> count == '0, "divider count not cleared when idle")

endmodule

`default_nettype wire

[src/ate_ctrl.sv]
// ----------------------------------------------------------------------------
// ate_ctrl
// Sequencer: accept a transaction, evaluate the poll decision, run the
// divider when needed and commit the result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ate_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire ate_pkg::ate_status_t status,
  output ate_pkg::ate_cmd_t        cmd
);
  import ate_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (!status.poll) begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIV;
        end else if (!status.query_changed && status.time_advanced) begin
          cmd.div_start  = 1'b1;
          cmd.div_use_dt = 1'b1;
          state_next     = ST_DIV;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DIV: begin
        if (status.div_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `ASSERT_CLK(a_accept_eval, (in_valid && !in_stall) |=> state == ST_EVAL,
              "accepted transaction not evaluated")
  `ASSERT_CLK(a_div_to_done, (state == ST_DIV && status.div_done) |=> state == ST_DONE,
              "divider result not taken")
  `ASSERT_CLK(a_commit_free, cmd.commit |-> status.out_free,
              "commit while output register busy")

endmodule

`default_nettype wire

[src/ate_dpath.sv]
// ----------------------------------------------------------------------------
// ate_dpath
// State registers, poll decision, rate update, extrapolation and the output
// register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ate_dpath (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire ate_pkg::ate_cmd_t          cmd,
  output ate_pkg::ate_status_t            status,
  input  wire logic [ate_pkg::TIME_W-1:0] clock_sample,
  input  wire logic [ate_pkg::CNT_W-1:0]  query_count,
  input  wire logic                       out_stall,
  output logic                            out_valid,
  output logic [ate_pkg::TIME_W-1:0]      estimated_time,
  output logic                            polled
);
  import ate_pkg::*;

  localparam int SUM_W = QUOT_W + 1;

  logic [CNT_W-1:0]  rate;
  logic [CNT_W-1:0]  calls;
  logic [CNT_W-1:0]  last_query;
  logic [TIME_W-1:0] last_poll_time;
  logic              started;
  logic [TIME_W-1:0] sample;
  logic [CNT_W-1:0]  query;

  logic [CNT_W-1:0]  threshold;
  logic [TIME_W-1:0] dt;
  logic [TIME_W-1:0] div_denom;
  logic              div_done;
  logic [QUOT_W-1:0] quot;
  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  sum_sh;
  logic [CNT_W-1:0]  rate_avg;
  logic [TIME_W:0]   extrap;
  logic [TIME_W-1:0] extrap_sat;

  always_comb begin
    threshold            = rate >> POLL_SHIFT;
    dt                   = sample - last_poll_time;
    status.query_changed = (query != last_query);
    status.poll          = (calls >= threshold) || status.query_changed;
    status.time_advanced = (sample > last_poll_time);
    status.div_done      = div_done;
    status.out_free      = !out_valid || !out_stall;
    div_denom            = cmd.div_use_dt ? dt : TIME_W'(rate);

    // 7/8 average: (8*rate - rate + q) / 8, saturated.
    sum      = (SUM_W'(rate) << 3) - SUM_W'(rate) + SUM_W'(quot);
    sum_sh   = sum >> 3;
    rate_avg = (sum_sh[SUM_W-1:CNT_W] != '0) ? '1 : sum_sh[CNT_W-1:0];

    extrap     = {1'b0, last_poll_time} + (TIME_W + 1)'(quot);
    extrap_sat = extrap[TIME_W] ? '1 : extrap[TIME_W-1:0];
  end

  ate_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .numer (calls),
    .denom (div_denom),
    .done  (div_done),
    .quot  (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rate       <= RATE_RESET;
      calls      <= '0;
      last_query <= '0;
      started    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.capture) begin
        started <= 1'b1;
        if (calls != '1) begin
          calls <= calls + CNT_W'(1);
        end
      end
      if (cmd.commit) begin
        if (status.poll) begin
          if (!status.query_changed) begin
            rate <= status.time_advanced ? rate_avg : '1;
          end
          last_query <= query;
          calls      <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample <= clock_sample;
      query  <= query_count;
    end
    if (cmd.capture && !started) begin
      last_poll_time <= clock_sample;
    end else if (cmd.commit && status.poll) begin
      last_poll_time <= sample;
    end
    if (cmd.commit) begin
      estimated_time <= status.poll ? sample : extrap_sat;
      polled         <= status.poll;
    end
  end

  `ASSERT_CLK(a_poll_reset_calls, (cmd.commit && status.poll) |=> calls == '0,
              "call count not cleared on poll")
  `ASSERT_CLK(a_commit_valid, cmd.commit |=> out_valid,
              "committed result not presented")
  `ASSERT_CLK(a_hold_stalled, (out_valid && out_stall) |=> out_valid && $stable(estimated_time) && $stable(polled),
              "stalled result changed")

endmodule

`default_nettype wire

[src/adaptive_time_extrapolator_core.sv]
// Flow: accept (ST_IDLE), evaluate (ST_EVAL), then on a poll with no rate
//   division (query change or no time advance) commit (ST_DONE) once the
//   output is free; otherwise the bit-serial divider (one quotient bit a
//   cycle) runs in ST_DIV first. One transaction at a time, result registered.
// Reset (rst, synchronous): rate 100000, calls and last query 0, not started,
//   no result pending; the first transaction latches its clock sample.
// ----------------------------------------------------------------------------
// adaptive_time_extrapolator_core
// Cheap wall-time estimate for a stream of call events: poll the true clock
// when the call count reaches rate/1024 or the query count moves, adapt the
// calls-per-second rate by a 7/8 average on plain polls (all ones if time did
// not advance), else output last poll time + calls/rate in 32.32 fixed point.
// ----------------------------------------------------------------------------
`default_nettype none

module adaptive_time_extrapolator_core (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // input transaction
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [ate_pkg::TIME_W-1:0] clock_sample,
  input  wire logic [ate_pkg::CNT_W-1:0]  query_count,
  // result transaction
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [ate_pkg::TIME_W-1:0]      estimated_time,
  output logic                            polled
);
  import ate_pkg::*;

  // Command and status between sequencer and datapath.
  ate_cmd_t    cmd;
  ate_status_t status;

  // Sequencer: take one transaction at a time, decide whether the divider runs
  // (rate update on a plain poll with time advanced, extrapolation offset
  // between polls), then commit once the output register is free. A result
  // waiting in the output register does not hold off the next input transaction.
  ate_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: state registers, shared divider, rate average, saturating
  // time add and the output register.
  ate_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .clock_sample   (clock_sample),
    .query_count    (query_count),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .estimated_time (estimated_time),
    .polled         (polled)
  );

endmodule

`default_nettype wire
